// File: sv/assert_macros.svh
// Assertion macros used by the converter's RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsv converter assertion failed");

// Clocked assertion that is also checked across reset.
`define ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsv converter reset assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_RST(lbl, clk, prop)

`endif

`endif

// File: sv/hsv_pkg.sv
package hsv_pkg;

    // Field widths.
    localparam int HUE_W  = 16;
    localparam int SAT_W  = 17;
    localparam int H_W    = 15;   // wrapped hue, below one full turn
    localparam int REM_W  = 12;   // position within a sector
    localparam int P_W    = 29;   // saturation times a sector position
    localparam int M_W    = 28;   // channel multiplier, 1.0 is 65536 * 3840
    localparam int VM_W   = 45;   // brightness times multiplier
    localparam int SUM_W  = VM_W + 5;
    localparam int CH_W   = 8;
    localparam int CH_LSB = 40;   // 255 / 3840 = 17 / 256, so 17 * vm >> 40

    // Pipeline layout.
    localparam int NUM_STG  = 6;
    localparam int STG_WRAP = 0;
    localparam int STG_SECT = 1;
    localparam int STG_PROD = 2;
    localparam int STG_MIX  = 3;
    localparam int STG_MUL  = 4;
    localparam int STG_OUT  = 5;

    // Channel lanes.
    localparam int NUM_LANE = 4;
    localparam int LANE_V   = 0;
    localparam int LANE_P   = 1;
    localparam int LANE_Q   = 2;
    localparam int LANE_T   = 3;

    // Constants.
    localparam int                       SECTOR_UNITS = 3840;
    localparam logic signed [HUE_W:0]    HUE_TURN     = 17'sd23040;
    localparam logic [SAT_W-1:0]         SAT_ONE      = 17'h10000;
    localparam logic [REM_W-1:0]         SECTOR_LEN   = 12'd3840;
    localparam logic [M_W-1:0]           M_ONE        = 28'd251658240;
    localparam logic [CH_W-1:0]          ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } t_sector;

    typedef logic [NUM_STG-1:0] t_stg_vec;

    typedef struct packed {
        t_stg_vec en;
        t_stg_vec vld;
    } t_pipe_ctl;

    typedef logic [NUM_LANE-1:0][VM_W-1:0] t_vm_vec;

endpackage

// File: sv/hsv_ctrl.sv
module hsv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    output logic               o_stall,
    output logic               o_valid,
    output hsv_pkg::t_pipe_ctl o_ctl
);
    import hsv_pkg::*;

    `include "assert_macros.svh"

    t_stg_vec r_vld;
    t_stg_vec n_vld;
    t_stg_vec w_en;
    logic     w_in_acc;
    logic     w_out_acc;

    // A stage moves when it is empty or when the stage after it moves.
    always_comb begin
        w_en[NUM_STG-1] = !r_vld[NUM_STG-1] || !i_stall;
        for (int i = NUM_STG - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
        n_vld = r_vld;
        for (int i = 0; i < NUM_STG; i++) begin
            if (w_en[i]) begin
                n_vld[i] = (i == 0) ? i_valid : r_vld[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_in_acc  = i_valid && w_en[0];
    assign w_out_acc = r_vld[NUM_STG-1] && !i_stall;

    assign o_stall   = !w_en[0];
    assign o_valid   = r_vld[NUM_STG-1];
    assign o_ctl.en  = w_en;
    assign o_ctl.vld = r_vld;

    `ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> (r_vld == '0))
    `ASSERT_CLK(a_stall_full, i_clk, i_rst_n, o_stall |-> ((&r_vld) && i_stall))
    `ASSERT_CLK(a_count, i_clk, i_rst_n, 1'b1 |=> ($countones(r_vld) == $past($countones(r_vld)) + $past(int'(w_in_acc)) - $past(int'(w_out_acc))))

endmodule

// File: sv/hsv_sector.sv
module hsv_sector (
    input  logic                       i_clk,
    input  hsv_pkg::t_pipe_ctl         i_ctl,
    input  logic signed [15:0]         i_hue,
    input  logic [16:0]                i_saturation,
    input  logic [16:0]                i_brightness,
    output hsv_pkg::t_sector           o_sector,
    output logic [hsv_pkg::REM_W-1:0]  o_rem,
    output logic [hsv_pkg::SAT_W-1:0]  o_sat,
    output logic [hsv_pkg::SAT_W-1:0]  o_val
);
    import hsv_pkg::*;

    logic [H_W-1:0]          r_h,    n_h;
    logic [SAT_W-1:0]        r_sat0, n_sat0;
    logic [SAT_W-1:0]        r_val0, n_val0;
    t_sector                 r_sec,  n_sec;
    logic [REM_W-1:0]        r_rem,  n_rem;
    logic [SAT_W-1:0]        r_sat1;
    logic [SAT_W-1:0]        r_val1;
    logic signed [HUE_W:0]   w_hue_x;
    logic signed [HUE_W:0]   w_hw;
    logic [H_W-1:0]          w_base;

    // Wrap the hue into one turn; values above 1.0 saturate.
    always_comb begin
        w_hue_x = {i_hue[HUE_W-1], i_hue};
        if (w_hue_x < -HUE_TURN) begin
            w_hw = w_hue_x + HUE_TURN + HUE_TURN;
        end else if (w_hue_x < 0) begin
            w_hw = w_hue_x + HUE_TURN;
        end else if (w_hue_x >= HUE_TURN) begin
            w_hw = w_hue_x - HUE_TURN;
        end else begin
            w_hw = w_hue_x;
        end
        n_h    = w_hw[H_W-1:0];
        n_sat0 = (i_saturation > SAT_ONE) ? SAT_ONE : i_saturation;
        n_val0 = (i_brightness > SAT_ONE) ? SAT_ONE : i_brightness;
    end

    // Sector by five parallel compares against the sector boundaries.
    always_comb begin
        n_sec  = SEC_R_Y;
        w_base = '0;
        for (int k = 1; k < 6; k++) begin
            if (r_h >= H_W'(k * SECTOR_UNITS)) begin
                n_sec  = t_sector'(3'(k));
                w_base = H_W'(k * SECTOR_UNITS);
            end
        end
        n_rem = REM_W'(r_h - w_base);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_WRAP]) begin
            r_h    <= n_h;
            r_sat0 <= n_sat0;
            r_val0 <= n_val0;
        end
        if (i_ctl.en[STG_SECT]) begin
            r_sec  <= n_sec;
            r_rem  <= n_rem;
            r_sat1 <= r_sat0;
            r_val1 <= r_val0;
        end
    end

    assign o_sector = r_sec;
    assign o_rem    = r_rem;
    assign o_sat    = r_sat1;
    assign o_val    = r_val1;

endmodule

// File: sv/hsv_mult.sv
module hsv_mult (
    input  logic                       i_clk,
    input  hsv_pkg::t_pipe_ctl         i_ctl,
    input  hsv_pkg::t_sector           i_sector,
    input  logic [hsv_pkg::REM_W-1:0]  i_rem,
    input  logic [hsv_pkg::SAT_W-1:0]  i_sat,
    input  logic [hsv_pkg::SAT_W-1:0]  i_val,
    output hsv_pkg::t_sector           o_sector,
    output hsv_pkg::t_vm_vec           o_vm
);
    import hsv_pkg::*;

    // Stage products: saturation times sector position.
    t_sector             r_sec2, r_sec3, r_sec4;
    logic [SAT_W-1:0]    r_val2, r_val3;
    logic [P_W-1:0]      r_pp,   n_pp;
    logic [P_W-1:0]      r_pq,   n_pq;
    logic [P_W-1:0]      r_pt,   n_pt;
    logic [M_W-1:0]      r_mp,   n_mp;
    logic [M_W-1:0]      r_mq,   n_mq;
    logic [M_W-1:0]      r_mt,   n_mt;
    t_vm_vec             r_vm,   n_vm;
    logic [REM_W-1:0]    w_cmp;

    always_comb begin
        w_cmp = SECTOR_LEN - i_rem;
        n_pp  = P_W'(SAT_ONE - i_sat) * P_W'(SECTOR_LEN);
        n_pq  = P_W'(i_sat) * P_W'(i_rem);
        n_pt  = P_W'(i_sat) * P_W'(w_cmp);
    end

    always_comb begin
        n_mp = r_pp[M_W-1:0];
        n_mq = M_W'(P_W'(M_ONE) - r_pq);
        n_mt = M_W'(P_W'(M_ONE) - r_pt);
    end

    always_comb begin
        n_vm[LANE_V] = VM_W'(r_val3) * VM_W'(M_ONE);
        n_vm[LANE_P] = VM_W'(r_val3) * VM_W'(r_mp);
        n_vm[LANE_Q] = VM_W'(r_val3) * VM_W'(r_mq);
        n_vm[LANE_T] = VM_W'(r_val3) * VM_W'(r_mt);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_PROD]) begin
            r_sec2 <= i_sector;
            r_val2 <= i_val;
            r_pp   <= n_pp;
            r_pq   <= n_pq;
            r_pt   <= n_pt;
        end
        if (i_ctl.en[STG_MIX]) begin
            r_sec3 <= r_sec2;
            r_val3 <= r_val2;
            r_mp   <= n_mp;
            r_mq   <= n_mq;
            r_mt   <= n_mt;
        end
        if (i_ctl.en[STG_MUL]) begin
            r_sec4 <= r_sec3;
            r_vm   <= n_vm;
        end
    end

    assign o_sector = r_sec4;
    assign o_vm     = r_vm;

endmodule

// File: sv/hsv_pack.sv
module hsv_pack (
    input  logic               i_clk,
    input  hsv_pkg::t_pipe_ctl i_ctl,
    input  hsv_pkg::t_sector   i_sector,
    input  hsv_pkg::t_vm_vec   i_vm,
    output logic [31:0]        o_packed_color
);
    import hsv_pkg::*;

    logic [NUM_LANE-1:0][CH_W-1:0] w_ch;
    logic [SUM_W-1:0]              w_sum [NUM_LANE];
    logic [CH_W-1:0]               w_r, w_g, w_b;
    logic [31:0]                   r_color, n_color;

    // 255 / 3840 reduces to 17 / 256: 17 * vm is a shift and an add.
    always_comb begin
        for (int l = 0; l < NUM_LANE; l++) begin
            w_sum[l] = (SUM_W'(i_vm[l]) << 4) + SUM_W'(i_vm[l]);
            w_ch[l]  = w_sum[l][CH_LSB +: CH_W];
        end
    end

    always_comb begin
        case (i_sector)
            SEC_R_Y: begin w_r = w_ch[LANE_V]; w_g = w_ch[LANE_T]; w_b = w_ch[LANE_P]; end
            SEC_Y_G: begin w_r = w_ch[LANE_Q]; w_g = w_ch[LANE_V]; w_b = w_ch[LANE_P]; end
            SEC_G_C: begin w_r = w_ch[LANE_P]; w_g = w_ch[LANE_V]; w_b = w_ch[LANE_T]; end
            SEC_C_B: begin w_r = w_ch[LANE_P]; w_g = w_ch[LANE_Q]; w_b = w_ch[LANE_V]; end
            SEC_B_M: begin w_r = w_ch[LANE_T]; w_g = w_ch[LANE_P]; w_b = w_ch[LANE_V]; end
            default: begin w_r = w_ch[LANE_V]; w_g = w_ch[LANE_P]; w_b = w_ch[LANE_Q]; end
        endcase
        n_color = {ALPHA_OPAQUE, w_r, w_g, w_b};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_OUT]) begin
            r_color <= n_color;
        end
    end

    assign o_packed_color = r_color;

endmodule

// File: sv/hsv_to_rgba_converter.sv
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_hue, i_saturation, i_brightness
// output    out        o_valid / i_stall     o_packed_color
//
// A beat accepted at a rising edge passes through the six register stages
// before o_valid rises for it and it can leave. One beat is accepted every
// cycle while o_stall is low.
// Reset (i_rst_n low at a rising edge) clears only the stage valid bits.
// A stall on the output holds each full stage with no empty stage after it;
// empty stages still fill, so o_stall rises only once all six stages hold a beat.

module hsv_to_rgba_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_hue,
    input  logic [16:0]        i_saturation,
    input  logic [16:0]        i_brightness,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_packed_color
);
    import hsv_pkg::*;

    t_pipe_ctl          w_ctl;
    t_sector            w_sec_a;
    t_sector            w_sec_b;
    logic [REM_W-1:0]   w_rem;
    logic [SAT_W-1:0]   w_sat;
    logic [SAT_W-1:0]   w_val;
    t_vm_vec            w_vm;

    // The controller holds a valid bit per stage and works out which stages
    // may load this cycle; the datapath registers follow those enables.
    hsv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (w_ctl)
    );

    // Stages one and two: the hue is wrapped into a single turn and the
    // saturation and brightness are clamped at 1.0, then the hue is split
    // into a sector number and the position within that sector.
    hsv_sector u_sector (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_sector     (w_sec_a),
        .o_rem        (w_rem),
        .o_sat        (w_sat),
        .o_val        (w_val)
    );

    // Stages three to five: saturation products, the p, q and t multipliers,
    // and then brightness times each multiplier, all kept exact.
    hsv_mult u_mult (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sector (w_sec_a),
        .i_rem    (w_rem),
        .i_sat    (w_sat),
        .i_val    (w_val),
        .o_sector (w_sec_b),
        .o_vm     (w_vm)
    );

    // Stage six: scaling to eight bits per channel, the six-way sector
    // selection and packing with opaque alpha into the output register.
    hsv_pack u_pack (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_sector       (w_sec_b),
        .i_vm           (w_vm),
        .o_packed_color (o_packed_color)
    );

endmodule
